@@ hdl/cascaded_range_index_extract_unit_assert.svh @@
// Assertion macros used by the checker of the index extraction unit
`ifndef CASCADED_RANGE_INDEX_EXTRACT_UNIT_ASSERT_SVH
`define CASCADED_RANGE_INDEX_EXTRACT_UNIT_ASSERT_SVH

// Same-cycle implication, off while reset is high
`define CRIE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is high
`define CRIE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset
`define CRIE_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/crie_pkg.sv @@
// Shared types, constants and helpers of the index extraction unit
package crie_pkg;

  localparam int          MAX_FACTORS_DEF = 6;
  localparam logic [31:0] MIX_MULT        = 32'd123456789;
  localparam int          MIX_ROT         = 11;
  localparam int          CFG_IDX_W       = 3;
  localparam logic [63:0] PAIR_RESET      = 64'h0000_0001_0000_0001;
  localparam logic [2:0]  COUNT_RESET     = 3'd1;

  // Register indexes on the write port
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR0 = 3'd2;

  // Data carried from cell to cell
  typedef struct packed {
    logic [31:0] state;
    logic [63:0] comp;
  } link_t;

  // Mode register, bit 1 interference, bit 0 feedback
  typedef struct packed {
    logic interfere;
    logic feedback;
  } mode_t;

  // One register write as seen by the cells
  typedef struct packed {
    logic                 en;
    logic [CFG_IDX_W-1:0] index;
    logic [63:0]          data;
  } cfg_wr_t;

  function automatic logic [31:0] rotl_mix(input logic [31:0] x);
    return {x[31-MIX_ROT:0], x[31:32-MIX_ROT]};
  endfunction

endpackage

@@ hdl/crie_mix.sv @@
// Three-stage key mixer: multiply, rotate, multiply, rotate, multiply
module crie_mix
  import crie_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        up_valid,
  output logic        up_ready,
  input  logic [31:0] key,
  output logic        dn_valid,
  input  logic        dn_ready,
  output logic [31:0] mixed
);

  logic        v0, v1, v2;
  logic        rdy0, rdy1, rdy2;
  logic [31:0] m0, m1, m2;

  // stage advances when empty or when its successor moves
  assign rdy2 = !v2 || dn_ready;
  assign rdy1 = !v1 || rdy2;
  assign rdy0 = !v0 || rdy1;
  assign up_ready = rdy0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy0) v0 <= up_valid;
      if (rdy1) v1 <= v0;
      if (rdy2) v2 <= v1;
    end
  end

  // payload, one multiply per stage
  always_ff @(posedge clk) begin
    if (rdy0 && up_valid) m0 <= key * MIX_MULT;
    if (rdy1 && v0)       m1 <= rotl_mix(m0) * MIX_MULT;
    if (rdy2 && v1)       m2 <= rotl_mix(m1) * MIX_MULT;
  end

  assign dn_valid = v2;
  assign mixed    = m2;

endmodule

@@ hdl/crie_cell.sv @@
// One factor cell: holds its factor pair and applies one digit step
module crie_cell
  import crie_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_wr_t cfg,
  input  mode_t   mode,
  input  logic    active,
  input  logic    up_valid,
  output logic    up_ready,
  input  link_t   up_data,
  output logic    dn_valid,
  input  logic    dn_ready,
  output link_t   dn_data
);

  logic [63:0] pair;
  logic [31:0] fac;
  logic [31:0] imul;
  logic        v0, v1, v2;
  logic        rdy0, rdy1, rdy2;
  // stage 0: after interference multiply
  logic [31:0] s0_state;
  link_t       s0_orig;
  // stage 1: partial products
  logic [63:0] s1_prod;
  logic [63:0] s1_clo;
  logic [31:0] s1_chi;
  link_t       s1_orig;
  // stage 2 combinational results
  logic [31:0] digit;
  link_t       step;
  link_t       s2_out;

  // factor pair register, written by its own index
  always_ff @(posedge clk) begin
    if (rst) begin
      pair <= PAIR_RESET;
    end else if (cfg.en && cfg.index == REG_PAIR0 + CFG_IDX_W'(IDX)) begin
      pair <= cfg.data;
    end
  end

  assign fac  = pair[31:0];
  assign imul = pair[63:32];

  // handshake across the three stages
  assign rdy2 = !v2 || dn_ready;
  assign rdy1 = !v1 || rdy2;
  assign rdy0 = !v0 || rdy1;
  assign up_ready = rdy0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy0) v0 <= up_valid;
      if (rdy1) v1 <= v0;
      if (rdy2) v2 <= v1;
    end
  end

  // digit and composite update from the registered products
  assign digit      = s1_prod[63:32];
  assign step.comp  = s1_clo + {s1_chi, 32'd0} + {32'd0, digit};
  assign step.state = s1_prod[31:0] + (mode.feedback ? digit : 32'd0);

  always_ff @(posedge clk) begin
    if (rdy0 && up_valid) begin
      s0_state <= (active && mode.interfere) ? up_data.state * imul : up_data.state;
      s0_orig  <= up_data;
    end
    if (rdy1 && v0) begin
      s1_prod <= s0_state * fac;
      s1_clo  <= s0_orig.comp[31:0] * fac;
      s1_chi  <= s0_orig.comp[63:32] * fac;
      s1_orig <= s0_orig;
    end
    // an unused cell passes its input through
    if (rdy2 && v1) s2_out <= active ? step : s1_orig;
  end

  assign dn_valid = v2;
  assign dn_data  = s2_out;

endmodule

@@ hdl/cascaded_range_index_extract_unit.sv @@
// Top level: key mixer followed by a chain of factor cells
// Usage:
//   Input channel: key with in_valid / in_stall. A request is taken at a
//   rising edge with in_valid high and in_stall low.
//   Output channel: composite_index with out_valid / out_stall, same rule.
//   Configuration: cfg_wr_en, cfg_index, cfg_data; index 0 factor count,
//   1 mode bits, 2 and up the factor pairs (multiplier high, factor low).
//   Write registers only while no request is in flight.
// Pipeline: the three mixer multiplies, then three stages per cell in
//   each of the MAX_FACTORS cells. Unused cells still pass the request
//   through, so the path does not depend on the count.
// Throughput: one request per cycle without out_stall; every stage holds
//   one request and moves whenever the stage after it is empty or moving.
// Stall: out_stall holds the result in the last cell; requests behind it
//   close up any gaps and in_stall rises only when every stage is full.
// Reset: synchronous, clears all stages; factor count goes to 1, mode to
//   0 and every pair to multiplier 1, factor 1.
module cascaded_range_index_extract_unit
  import crie_pkg::*;
#(
  parameter int MAX_FACTORS = MAX_FACTORS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [31:0]          key,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [63:0]          composite_index,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  logic [2:0]  factor_count;
  logic [1:0]  mode_bits;
  cfg_wr_t     cfg;
  mode_t       mode;
  logic        mix_ready;
  logic [31:0] mixed;
  logic        lnk_valid [MAX_FACTORS+1];
  logic        lnk_ready [MAX_FACTORS+1];
  link_t       lnk_data  [MAX_FACTORS+1];

  // global configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      factor_count <= COUNT_RESET;
      mode_bits    <= 2'd0;
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_COUNT) factor_count <= cfg_data[2:0];
      if (cfg_index == REG_MODE)  mode_bits    <= cfg_data[1:0];
    end
  end

  assign cfg.en    = cfg_wr_en;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;
  assign mode      = mode_t'(mode_bits);

  assign in_stall = !mix_ready;

  crie_mix u_mix (
    .clk      (clk),
    .rst      (rst),
    .up_valid (in_valid),
    .up_ready (mix_ready),
    .key      (key),
    .dn_valid (lnk_valid[0]),
    .dn_ready (lnk_ready[0]),
    .mixed    (mixed)
  );

  assign lnk_data[0].state = mixed;
  assign lnk_data[0].comp  = 64'd0;

  // chain of cells; a cell is active when its position is below the count
  for (genvar i = 0; i < MAX_FACTORS; i++) begin : g_cell
    crie_cell #(
      .IDX (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cfg      (cfg),
      .mode     (mode),
      .active   (factor_count > 3'(i)),
      .up_valid (lnk_valid[i]),
      .up_ready (lnk_ready[i]),
      .up_data  (lnk_data[i]),
      .dn_valid (lnk_valid[i+1]),
      .dn_ready (lnk_ready[i+1]),
      .dn_data  (lnk_data[i+1])
    );
  end

  assign lnk_ready[MAX_FACTORS] = !out_stall;
  assign out_valid              = lnk_valid[MAX_FACTORS];
  assign composite_index        = lnk_data[MAX_FACTORS].comp;

endmodule

@@ hdl/crie_checker.sv @@
// Port-level checker of the index extraction unit, bound to the top level
`include "cascaded_range_index_extract_unit_assert.svh"

module crie_checker
  import crie_pkg::*;
#(
  parameter int MAX_FACTORS = MAX_FACTORS_DEF
) (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] composite_index
);

  localparam int DEPTH = 3 + 3 * MAX_FACTORS;
  localparam int CNT_W = $clog2(DEPTH + 2);

  logic             in_take;
  logic             out_take;
  logic [CNT_W-1:0] outstanding;

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  // requests taken and not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + CNT_W'(in_take) - CNT_W'(out_take);
    end
  end

  `CRIE_ASSERT_RST(a_reset_empty, rst, !out_valid, "result shown right after reset")
  `CRIE_ASSERT_SAME(a_no_invented, out_valid, outstanding != '0, "result with no request")
  `CRIE_ASSERT_SAME(a_capacity, 1'b1, outstanding <= CNT_W'(DEPTH), "more requests than stages")
  `CRIE_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(composite_index), "stalled result changed")

endmodule

bind cascaded_range_index_extract_unit crie_checker #(
  .MAX_FACTORS (MAX_FACTORS)
) u_crie_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .composite_index (composite_index)
);
